// ===== hw/rtl/lsbbp_pkg.sv =====
// Shared constants for the LSB-first bit packer: store geometry, field
// widths and item kind codes. No dependencies.
`default_nettype none

package lsbbp_pkg;

    // Byte store geometry
    localparam int BUF_BYTES = 256;
    localparam int ADDR_W    = $clog2(BUF_BYTES);
    localparam int BUF_BITS  = BUF_BYTES * 8;

    // Field widths
    localparam int POS_W    = 12;
    localparam int CNT_W    = 6;
    localparam int KIND_W   = 3;
    localparam int MAX_BITS = 32;
    localparam int POS_MAX  = (1 << POS_W) - 1;

    // Highest position any write may reach, before the capacity register
    localparam int LIM_CEIL = (BUF_BITS < POS_MAX) ? BUF_BITS : POS_MAX;

    // Input stream packing
    localparam int IN_DATA_W = 72;
    localparam int OUT_DATA_W = 64;

    // Capacity after reset
    localparam logic [POS_W-1:0] CAP_RESET = POS_W'(2048);

    // Item kinds
    localparam logic [KIND_W-1:0] KIND_INIT    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_LOAD    = 3'd1;
    localparam logic [KIND_W-1:0] KIND_READ    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_WRITE   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_APPEND  = 3'd4;
    localparam logic [KIND_W-1:0] KIND_SET_POS = 3'd5;

endpackage

`default_nettype wire

// ===== hw/rtl/lsb_first_bit_packer.sv =====
// Top level of the LSB-first bit packer: byte store, bit-serial read and
// OR-write engine and the result register. Depends on lsbbp_pkg.
//
//   Channel   Direction  Contents
//   s_axis    in         tuser: kind; tdata: count, value, position, address, byte
//   m_axis    out        tdata: read value, bits done, failed, position, length
//   i_cfg_*   in         capacity in bits, written at any edge with i_cfg_wr_en high
//
// Init, load_byte, set_pos and unused kinds go from idle straight to the output
// state. A read, write or append of n bits ends there too and moves one bit per
// cycle, plus a fetch and latch of each byte through the single memory read
// port. Reset is synchronous; the store reads as zero after reset
// through per-byte valid flags, so no clearing pass is needed. A new item is
// taken while the previous result waits in the output register; a stalled
// output only holds the block once the next result is ready.
`default_nettype none

module lsb_first_bit_packer
    import lsbbp_pkg::*;
(
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    // Configuration
    input  wire                     i_cfg_wr_en,
    input  wire [POS_W-1:0]         i_cfg_wr_data,
    // Input stream
    input  wire                     s_axis_tvalid,
    output logic                    s_axis_tready,
    // tdata from bit 0: bit_count[5:0], write_value[37:6], position[49:38],
    // byte_addr[57:50], byte_value[65:58], zero pad [71:66]
    input  wire [IN_DATA_W-1:0]     s_axis_tdata,
    // tuser from bit 0: kind[2:0]
    input  wire [KIND_W-1:0]        s_axis_tuser,
    // Result stream
    output logic                    m_axis_tvalid,
    input  wire                     m_axis_tready,
    // tdata from bit 0: read_value[31:0], bits_done[37:32], read_failed[38],
    // cur_position[50:39], cur_length[62:51], zero pad [63]
    output logic [OUT_DATA_W-1:0]   m_axis_tdata
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_LATCH = 3'd2;
    localparam logic [2:0] S_BIT   = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;

    // Input fields
    logic [CNT_W-1:0]    in_count;
    logic [MAX_BITS-1:0] in_value;
    logic [POS_W-1:0]    in_pos;
    logic [7:0]          in_addr;
    logic [7:0]          in_byte;
    logic [CNT_W-1:0]    in_count_sat;

    assign in_count = s_axis_tdata[5:0];
    assign in_value = s_axis_tdata[37:6];
    assign in_pos   = s_axis_tdata[49:38];
    assign in_addr  = s_axis_tdata[57:50];
    assign in_byte  = s_axis_tdata[65:58];
    assign in_count_sat = (in_count > CNT_W'(MAX_BITS)) ? CNT_W'(MAX_BITS) : in_count;

    // Control and payload registers
    logic [2:0]          r_state;
    logic [POS_W-1:0]    r_pos;
    logic [POS_W-1:0]    r_len;
    logic [POS_W-1:0]    r_cap;
    logic                r_out_vld;
    logic                r_is_rd;
    logic [CNT_W-1:0]    r_n;
    logic [CNT_W-1:0]    r_cnt;
    logic [MAX_BITS-1:0] r_wv;
    logic [MAX_BITS-1:0] r_rdata;
    logic                r_failed;
    logic [7:0]          r_byte;
    logic [OUT_DATA_W-1:0] r_out_data;

    // Byte store with a valid flag per byte
    logic [7:0]          r_mem [BUF_BYTES];
    logic [7:0]          r_mem_q;
    logic [BUF_BYTES-1:0] r_vld;

    logic                mem_we;
    logic [ADDR_W-1:0]   mem_waddr;
    logic [7:0]          mem_wdata;
    logic [ADDR_W-1:0]   pos_addr;

    // Bit engine signals
    logic [POS_W-1:0]    lim;
    logic                idx_ok;
    logic                go_on;
    logic [2:0]          bit_sel;
    logic [POS_W-1:0]    pos_inc;
    logic [CNT_W-1:0]    cnt_inc;
    logic                stop_next;
    logic [7:0]          n_byte;
    logic                accept;

    assign accept        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_data;

    // Effective write limit from the capacity register
    assign lim = (32'(r_cap) > 32'(LIM_CEIL)) ? POS_W'(LIM_CEIL) : r_cap;

    // Byte index of the current position and whether it lies in the store
    assign pos_addr = ADDR_W'(r_pos[POS_W-1:3]);
    assign idx_ok   = (32'(r_pos[POS_W-1:3]) < 32'(BUF_BYTES));

    // Loop condition at the head of each byte
    assign go_on = (r_cnt < r_n) && (r_is_rd ? (r_pos < r_len) : (r_pos < lim));

    assign bit_sel = r_pos[2:0];
    assign pos_inc = r_pos + POS_W'(1);
    assign cnt_inc = r_cnt + CNT_W'(1);
    assign n_byte  = r_byte | (8'(r_wv[0]) << bit_sel);

    // True when the bit being handled now is the last of this item
    assign stop_next = (cnt_inc >= r_n) ||
                       (r_is_rd ? (pos_inc >= r_len) : (pos_inc >= lim));

    // Memory write port: direct byte loads, or write-back at the end of a byte or of the item
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = pos_addr;
        mem_wdata = n_byte;
        if (accept && (s_axis_tuser == KIND_LOAD) && (32'(in_addr) < 32'(BUF_BYTES))) begin
            mem_we    = 1'b1;
            mem_waddr = ADDR_W'(in_addr);
            mem_wdata = in_byte;
        end else if ((r_state == S_BIT) && !r_is_rd && idx_ok &&
                     ((bit_sel == 3'd7) || stop_next)) begin
            mem_we = 1'b1;
        end
    end

    // Store array: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_mem_q <= r_mem[pos_addr];
    end

    // Valid flags: a byte never written reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (mem_we) begin
            r_vld[mem_waddr] <= 1'b1;
        end
    end

    // Capacity register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RESET;
        end else if (i_cfg_wr_en) begin
            r_cap <= i_cfg_wr_data;
        end
    end

    // Sequencer, position, length and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_pos     <= '0;
            r_len     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            // A waiting result is dropped on its transfer unless the next one replaces it
            if (r_out_vld && m_axis_tready && (r_state != S_OUT)) begin
                r_out_vld <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_n      <= in_count_sat;
                        r_cnt    <= '0;
                        r_wv     <= in_value;
                        r_rdata  <= '0;
                        r_failed <= (s_axis_tuser == KIND_READ) && (r_len <= r_pos);
                        r_is_rd  <= (s_axis_tuser == KIND_READ);
                        unique case (s_axis_tuser)
                            KIND_INIT: begin
                                r_len   <= in_pos;
                                r_pos   <= '0;
                                r_state <= S_OUT;
                            end
                            KIND_READ: begin
                                r_state <= S_CHECK;
                            end
                            KIND_WRITE: begin
                                r_state <= S_CHECK;
                            end
                            KIND_APPEND: begin
                                r_pos   <= r_len;
                                r_state <= S_CHECK;
                            end
                            KIND_SET_POS: begin
                                r_pos   <= in_pos;
                                r_state <= S_OUT;
                            end
                            default: begin
                                // Byte loads go straight to the store; other codes do nothing
                                r_state <= S_OUT;
                            end
                        endcase
                    end
                end
                S_CHECK: begin
                    // The store read of the current byte is issued here
                    r_state <= go_on ? S_LATCH : S_OUT;
                end
                S_LATCH: begin
                    r_byte  <= (idx_ok && r_vld[pos_addr]) ? r_mem_q : 8'h00;
                    r_state <= S_BIT;
                end
                S_BIT: begin
                    // One bit per cycle; leave at the byte boundary or when done
                    if (r_is_rd) begin
                        r_rdata[r_cnt[CNT_W-2:0]] <= r_byte[bit_sel];
                    end else begin
                        r_byte <= n_byte;
                        if (r_len < pos_inc) begin
                            r_len <= r_len + POS_W'(1);
                        end
                    end
                    r_wv  <= r_wv >> 1;
                    r_cnt <= cnt_inc;
                    r_pos <= pos_inc;
                    if ((bit_sel == 3'd7) || stop_next) begin
                        r_state <= S_CHECK;
                    end
                end
                S_OUT: begin
                    if (!r_out_vld || m_axis_tready) begin
                        r_out_data <= {1'b0, r_len, r_pos, r_failed, r_cnt, r_rdata};
                        r_out_vld  <= 1'b1;
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/lsbbp_checker.sv =====
// Port-level checks for the LSB-first bit packer, bound to the top level.
// Depends on lsbbp_pkg and lsb_first_bit_packer.
`default_nettype none

module lsbbp_checker
    import lsbbp_pkg::*;
(
    input wire                   i_clk,
    input wire                   i_rst_n,
    input wire                   m_axis_tvalid,
    input wire                   m_axis_tready,
    input wire [OUT_DATA_W-1:0]  m_axis_tdata
);

    // A result transfer that is offered stays offered until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
        else $error("result withdrawn before transfer");

    // No result is offered right after reset
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result offered after reset");

    // Bits done never exceed the per-item maximum
    a_done_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[37:32] <= CNT_W'(MAX_BITS)))
        else $error("bits done out of range");

    // A failed read moves no bits and returns zero data
    a_failed_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[38]) |->
            ((m_axis_tdata[37:32] == '0) && (m_axis_tdata[31:0] == '0)))
        else $error("failed read carries data");

    // Read data is zero when no bits were moved
    a_data_within_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tdata[37:32] == '0)) |-> (m_axis_tdata[31:0] == '0))
        else $error("read data without bits done");

endmodule

bind lsb_first_bit_packer lsbbp_checker u_lsbbp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
